@@ rtl/alr_pkg.sv @@
// ----------------------------------------------------------------------------
// alr_pkg
// Shared constants, types and helpers of the linear resampler.
// ----------------------------------------------------------------------------
package alr_pkg;

  localparam int MAX_BLOCK_FRAMES = 4096;
  localparam int MAX_RESULTS      = 64;

  localparam int SAMPLE_W = 16;
  localparam int RATE_W   = 18;
  localparam int VOL_W    = 7;
  localparam int FRAMES_W = 13;
  localparam int IDX_W    = $clog2(MAX_BLOCK_FRAMES);
  localparam int CNT_W    = 16;
  localparam int FRAC_W   = 32;
  localparam int POS_W    = IDX_W + FRAC_W;
  localparam int BUF_AW   = $clog2(MAX_RESULTS);
  localparam int KEPT_W   = $clog2(MAX_RESULTS + 1);
  localparam int DIV_W    = POS_W;
  localparam int DVS_W    = RATE_W;
  localparam int MIX_W    = SAMPLE_W + 1;
  localparam int VPROD_W  = MIX_W + VOL_W + 1;
  localparam int IPROD_W  = 2 * MIX_W;

  // divide by 100 as multiply by ceil(2^30/100), exact for magnitudes below 2^23
  localparam int VOL_SHIFT = 30;
  localparam int VREC_W    = 24;

  localparam int APB_AW = 4;
  localparam int APB_DW = 32;

  localparam logic [RATE_W-1:0] RESET_SRC_RATE    = RATE_W'(48000);
  localparam logic [RATE_W-1:0] RESET_OUTPUT_RATE = RATE_W'(48000);
  localparam logic [VOL_W-1:0]  RESET_VOLUME      = VOL_W'(100);
  localparam logic [VREC_W-1:0] VOL_RECIP         =
    VREC_W'(((64'd1 << VOL_SHIFT) + 64'd99) / 64'd100);

  localparam logic [1:0] REG_SRC_RATE    = 2'd0;
  localparam logic [1:0] REG_OUTPUT_RATE = 2'd1;
  localparam logic [1:0] REG_VOLUME      = 2'd2;

  typedef enum logic {DIV_COUNT, DIV_STEP} div_sel_e;
  typedef enum logic {EMIT_SAMPLE, EMIT_INTERP} emit_sel_e;

  typedef struct packed {
    logic      load;
    logic      mix_mul;
    logic      vol_mul;
    logic      set_s_mono;
    logic      set_s_vol;
    logic      div_start;
    div_sel_e  div_sel;
    logic      blk_mul;
    logic      set_count;
    logic      set_step;
    logic      mark_before;
    logic      int_mul;
    logic      emit;
    emit_sel_e emit_sel;
    logic      count;
    logic      finish;
    logic      rd;
    logic      rd_next;
  } dp_cmd_t;

  typedef struct packed {
    logic div_done;
    logic mode;
    logic rates_eq;
    logic first;
    logic step_needed;
    logic flat;
    logic fill;
    logic interp;
    logic last;
    logic kept_zero;
    logic rd_last;
  } dp_status_t;

  function automatic logic signed [SAMPLE_W-1:0] sat16(input logic signed [MIX_W:0] v);
    logic signed [MIX_W:0] lo;
    logic signed [MIX_W:0] hi;
    lo = -(MIX_W+1)'(32768);
    hi = (MIX_W+1)'(32767);
    if (v < lo) return SAMPLE_W'(lo);
    else if (v > hi) return SAMPLE_W'(hi);
    else return v[SAMPLE_W-1:0];
  endfunction

endpackage

@@ rtl/alr_if.sv @@
// ----------------------------------------------------------------------------
// alr_in_if / alr_out_if
// Valid/ready channels for input frames and resampled results.
// ----------------------------------------------------------------------------
interface alr_in_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  mode;
  logic signed [alr_pkg::SAMPLE_W-1:0]   sample_a;
  logic signed [alr_pkg::SAMPLE_W-1:0]   sample_b;
  logic        [alr_pkg::FRAMES_W-1:0]   block_frames;
  modport source (output valid, mode, sample_a, sample_b, block_frames, input ready);
  modport sink   (input valid, mode, sample_a, sample_b, block_frames, output ready);
endinterface

interface alr_out_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [alr_pkg::SAMPLE_W-1:0]   out_sample;
  logic                                  last_of_run;
  logic                                  end_of_block;
  logic                                  overflow;
  modport source (output valid, out_sample, last_of_run, end_of_block, overflow, input ready);
  modport sink   (input valid, out_sample, last_of_run, end_of_block, overflow, output ready);
endinterface

@@ rtl/audio_block_linear_resampler_top.sv @@
// ----------------------------------------------------------------------------
// audio_block_linear_resampler_top
// Linear-interpolation sample-rate converter with APB configuration.
// ----------------------------------------------------------------------------
// One frame is taken at a time; the next is accepted only after every result
// of the current one has been delivered. A mono frame that starts no block
// is captured, passes the mix and dispatch states, then runs the interpolation
// loop (a single pass state with equal rates) and is closed; each interpolated
// output takes a multiply and an emit state, each output repeated from the
// frame an emit, and each delivered result a read and a show state. A stereo
// frame adds the volume multiply and scale states. The first frame of a block
// with unequal rates adds the output-count divide and the step divide: both
// share one bit-serial 44-bit divider. Outputs cut beyond 64 still step, one
// per cycle (interpolated ones via both states): frame time grows with them.
// Registers: 0x0 input rate, 0x4 output rate, 0x8 volume.
// ----------------------------------------------------------------------------
module audio_block_linear_resampler_top
  import alr_pkg::*;
(
  input  logic                         clk_i,
  input  logic                         rst_ni,
  alr_in_if.sink                       in_i,
  alr_out_if.source                    out_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [alr_pkg::APB_AW-1:0]   paddr,
  input  logic [alr_pkg::APB_DW-1:0]   pwdata,
  output logic [alr_pkg::APB_DW-1:0]   prdata,
  output logic                         pready
);
  logic [RATE_W-1:0] src_rate_q, output_rate_q;
  logic [VOL_W-1:0]  volume_q;
  logic              wr_en;
  dp_cmd_t           cmd;
  dp_status_t        status;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      src_rate_q    <= RESET_SRC_RATE;
      output_rate_q <= RESET_OUTPUT_RATE;
      volume_q      <= RESET_VOLUME;
    end else if (wr_en) begin
      unique case (paddr[3:2])
        REG_SRC_RATE:    src_rate_q    <= pwdata[RATE_W-1:0];
        REG_OUTPUT_RATE: output_rate_q <= pwdata[RATE_W-1:0];
        REG_VOLUME:      volume_q      <= pwdata[VOL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_SRC_RATE:    prdata = APB_DW'(src_rate_q);
      REG_OUTPUT_RATE: prdata = APB_DW'(output_rate_q);
      REG_VOLUME:      prdata = APB_DW'(volume_q);
      default:         prdata = '0;
    endcase
  end

  alr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  alr_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .src_rate_i     (src_rate_q),
    .output_rate_i  (output_rate_q),
    .volume_i       (volume_q),
    .mode_i         (in_i.mode),
    .sample_a_i     (in_i.sample_a),
    .sample_b_i     (in_i.sample_b),
    .block_frames_i (in_i.block_frames),
    .cmd_i          (cmd),
    .status_o       (status),
    .out_sample_o   (out_o.out_sample),
    .last_of_run_o  (out_o.last_of_run),
    .end_of_block_o (out_o.end_of_block),
    .overflow_o     (out_o.overflow)
  );

endmodule

@@ rtl/alr_div.sv @@
// ----------------------------------------------------------------------------
// alr_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module alr_div
  import alr_pkg::*;
(
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [alr_pkg::DIV_W-1:0]      dividend_i,
  input  logic [alr_pkg::DVS_W-1:0]      divisor_i,
  output logic [alr_pkg::DIV_W-1:0]      quotient_o,
  output logic [alr_pkg::DVS_W-1:0]      remainder_o,
  output logic                           done_o
);
  localparam int CW = $clog2(DIV_W);

  logic [DVS_W:0]   rem_q, rem_d;
  logic [DIV_W-1:0] quo_q, quo_d;
  logic [DVS_W-1:0] dvs_q;
  logic [CW-1:0]    cnt_q;
  logic             busy_q;
  logic [DVS_W:0]   shifted;
  logic             ge;

  always_comb begin
    shifted = {rem_q[DVS_W-1:0], quo_q[DIV_W-1]};
    ge      = shifted >= {1'b0, dvs_q};
    rem_d   = ge ? shifted - {1'b0, dvs_q} : shifted;
    quo_d   = {quo_q[DIV_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      cnt_q  <= CW'(DIV_W - 1);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == '0) busy_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= quo_d;
    end
  end

  assign quotient_o  = quo_q;
  assign remainder_o = rem_q[DVS_W-1:0];
  assign done_o      = ~busy_q;

endmodule

@@ rtl/alr_dp.sv @@
// ----------------------------------------------------------------------------
// alr_dp
// Resampler datapath: downmix, block setup, interpolation, result buffer.
// ----------------------------------------------------------------------------
module alr_dp
  import alr_pkg::*;
(
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic [alr_pkg::RATE_W-1:0]          src_rate_i,
  input  logic [alr_pkg::RATE_W-1:0]          output_rate_i,
  input  logic [alr_pkg::VOL_W-1:0]           volume_i,
  input  logic                                mode_i,
  input  logic signed [alr_pkg::SAMPLE_W-1:0] sample_a_i,
  input  logic signed [alr_pkg::SAMPLE_W-1:0] sample_b_i,
  input  logic [alr_pkg::FRAMES_W-1:0]        block_frames_i,
  input  alr_pkg::dp_cmd_t                    cmd_i,
  output alr_pkg::dp_status_t                 status_o,
  output logic signed [alr_pkg::SAMPLE_W-1:0] out_sample_o,
  output logic                                last_of_run_o,
  output logic                                end_of_block_o,
  output logic                                overflow_o
);
  localparam logic [FRAMES_W-1:0] FRAMES_MAX = FRAMES_W'(MAX_BLOCK_FRAMES);

  // captured item
  logic                       mode_q;
  logic signed [SAMPLE_W-1:0] a_q, b_q, s_q;
  logic [FRAMES_W-1:0]        frames_q, frames_cl;

  // block state
  logic [RATE_W-1:0]          rem_q;
  logic [IDX_W-1:0]           frame_idx_q;
  logic signed [SAMPLE_W-1:0] prev_q;
  logic [CNT_W-1:0]           cnt_q, emitted_q;
  logic [POS_W-1:0]           pos_q, step_q;

  // work registers
  logic signed [VPROD_W-1:0]  vprod_q;
  logic [MIX_W-1:0]           vq_q;
  logic [FRAMES_W+RATE_W-1:0] bprod_q;
  logic signed [IPROD_W-1:0]  iprod_q;
  logic                       before_lt_q, eob_q, over_q;
  logic [KEPT_W-1:0]          kept_q;
  logic [BUF_AW-1:0]          rd_idx_q;
  logic signed [SAMPLE_W-1:0] rdata_q;
  logic signed [SAMPLE_W-1:0] buf_mem [MAX_RESULTS];

  logic signed [MIX_W-1:0]    sum, mixed, diff;
  logic [VPROD_W-1:0]         vmag;
  logic [VPROD_W+VREC_W-1:0]  vscaled;
  logic [DIV_W-1:0]           dividend;
  logic [DVS_W-1:0]           divisor;
  logic [DIV_W-1:0]           quo;
  logic [DVS_W-1:0]           drem;
  logic                       div_done;
  logic [FRAMES_W-1:0]        fm1;
  logic signed [MIX_W:0]      vsigned, isum;
  logic signed [SAMPLE_W-1:0] ival, wdata;
  logic                       last;
  logic [31:0]                cnt_sum;

  always_comb begin
    if (block_frames_i == '0) frames_cl = FRAMES_W'(1);
    else if (block_frames_i > FRAMES_MAX) frames_cl = FRAMES_MAX;
    else frames_cl = block_frames_i;
  end

  always_comb begin
    sum     = MIX_W'(a_q) + MIX_W'(b_q);
    // halve, rounding toward zero
    mixed   = (sum < 0) ? (sum + MIX_W'(1)) >>> 1 : sum >>> 1;
    vmag    = (vprod_q < 0) ? VPROD_W'(-vprod_q) : VPROD_W'(vprod_q);
    vscaled = vmag * VOL_RECIP;
    fm1     = frames_q - FRAMES_W'(1);
    cnt_sum = 32'(bprod_q) + 32'(rem_q);
    unique case (cmd_i.div_sel)
      DIV_COUNT: begin
        dividend = DIV_W'(cnt_sum);
        divisor  = (src_rate_i == '0) ? DVS_W'(1) : src_rate_i;
      end
      default: begin
        dividend = {fm1[IDX_W-1:0], {FRAC_W{1'b0}}};
        divisor  = DVS_W'(cnt_q - CNT_W'(1));
      end
    endcase
    vsigned = (vprod_q < 0) ? -$signed({1'b0, vq_q})
                            : $signed({1'b0, vq_q});
    diff    = MIX_W'(s_q) - MIX_W'(prev_q);
    // floor of the product over 2^16 is an arithmetic shift
    isum    = (MIX_W+1)'(prev_q) + iprod_q[IPROD_W-1:16];
    ival    = sat16(isum);
    wdata   = (cmd_i.emit_sel == EMIT_INTERP) ? ival : s_q;
    last    = (FRAMES_W'(frame_idx_q) + FRAMES_W'(1)) >= frames_q;
  end

  alr_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (cmd_i.div_start),
    .dividend_i  (dividend),
    .divisor_i   (divisor),
    .quotient_o  (quo),
    .remainder_o (drem),
    .done_o      (div_done)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mode_q   <= mode_i;
      a_q      <= sample_a_i;
      b_q      <= sample_b_i;
      frames_q <= frames_cl;
    end
    if (cmd_i.mix_mul) vprod_q <= VPROD_W'(mixed * $signed({1'b0, volume_i}));
    if (cmd_i.vol_mul) vq_q <= vscaled[VOL_SHIFT +: MIX_W];
    if (cmd_i.set_s_mono) s_q <= a_q;
    if (cmd_i.set_s_vol) s_q <= sat16(vsigned);
    if (cmd_i.blk_mul) bprod_q <= (FRAMES_W+RATE_W)'(frames_q * output_rate_i);
    if (cmd_i.int_mul) iprod_q <= diff * $signed({1'b0, pos_q[FRAC_W-1:16]});
    if (cmd_i.emit && kept_q < KEPT_W'(MAX_RESULTS)) buf_mem[kept_q[BUF_AW-1:0]] <= wdata;
    if (cmd_i.rd) rdata_q <= buf_mem[rd_idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q       <= '0;
      frame_idx_q <= '0;
      prev_q      <= '0;
      cnt_q       <= '0;
      emitted_q   <= '0;
      pos_q       <= '0;
      step_q      <= '0;
      before_lt_q <= 1'b0;
      eob_q       <= 1'b0;
      over_q      <= 1'b0;
      kept_q      <= '0;
      rd_idx_q    <= '0;
    end else begin
      if (cmd_i.load) begin
        kept_q   <= '0;
        over_q   <= 1'b0;
        rd_idx_q <= '0;
      end
      if (cmd_i.set_count) begin
        cnt_q     <= (quo[DIV_W-1:CNT_W] != '0) ? {CNT_W{1'b1}} : quo[CNT_W-1:0];
        rem_q     <= drem;
        emitted_q <= '0;
        pos_q     <= '0;
        step_q    <= '0;
      end
      if (cmd_i.set_step) step_q <= quo;
      if (cmd_i.mark_before) before_lt_q <= emitted_q < cnt_q;
      if (cmd_i.emit) begin
        if (kept_q < KEPT_W'(MAX_RESULTS)) kept_q <= kept_q + 1'b1;
        else over_q <= 1'b1;
      end
      if (cmd_i.count) begin
        emitted_q <= emitted_q + 1'b1;
        if (cmd_i.emit_sel == EMIT_INTERP) pos_q <= pos_q + step_q;
      end
      if (cmd_i.finish) begin
        prev_q      <= s_q;
        frame_idx_q <= last ? '0 : frame_idx_q + 1'b1;
        eob_q       <= (src_rate_i == output_rate_i) ? last
                       : (before_lt_q && emitted_q == cnt_q);
      end
      if (cmd_i.rd_next) rd_idx_q <= rd_idx_q + 1'b1;
    end
  end

  always_comb begin
    status_o.div_done    = div_done;
    status_o.mode        = mode_q;
    status_o.rates_eq    = src_rate_i == output_rate_i;
    status_o.first       = frame_idx_q == '0;
    status_o.step_needed = cnt_q >= CNT_W'(2) && frames_q >= FRAMES_W'(2);
    status_o.flat        = cnt_q == CNT_W'(1) || frames_q == FRAMES_W'(1);
    status_o.fill        = emitted_q < cnt_q;
    status_o.interp      = (emitted_q < cnt_q) && (pos_q[POS_W-1:FRAC_W] < frame_idx_q);
    status_o.last        = last;
    status_o.kept_zero   = kept_q == '0;
    status_o.rd_last     = (KEPT_W'(rd_idx_q) + KEPT_W'(1)) == kept_q;
  end

  assign out_sample_o   = rdata_q;
  assign last_of_run_o  = status_o.rd_last;
  assign end_of_block_o = status_o.rd_last & eob_q;
  assign overflow_o     = over_q;

  a_kept_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    kept_q <= KEPT_W'(MAX_RESULTS)) else $error("result buffer count out of range");
  a_emitted_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emitted_q <= cnt_q) else $error("emitted more outputs than the block holds");
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_start |-> div_done) else $error("divider restarted while busy");
  a_drop_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    over_q |-> kept_q == KEPT_W'(MAX_RESULTS)) else $error("drop flagged before buffer full");

endmodule

@@ rtl/alr_ctrl.sv @@
// ----------------------------------------------------------------------------
// alr_ctrl
// Sequencer: steps the datapath through one frame and drains its results.
// ----------------------------------------------------------------------------
module alr_ctrl
  import alr_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  input  alr_pkg::dp_status_t  status_i,
  output alr_pkg::dp_cmd_t     cmd_o
);
  typedef enum logic [4:0] {
    S_IDLE, S_MIX, S_VMUL, S_VSCALE, S_DISPATCH, S_PASS, S_BMUL, S_CSTART,
    S_CWAIT, S_CHECK, S_SSTART, S_SWAIT, S_MARK, S_FLAT, S_ILOOP, S_IEMIT,
    S_FILL, S_FINISH, S_READ, S_SHOW
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: if (in_valid_i) begin
        cmd_o.load = 1'b1;
        state_d    = S_MIX;
      end
      S_MIX: begin
        if (status_i.mode) begin
          cmd_o.mix_mul = 1'b1;
          state_d       = S_VMUL;
        end else begin
          cmd_o.set_s_mono = 1'b1;
          state_d          = S_DISPATCH;
        end
      end
      S_VMUL: begin
        cmd_o.vol_mul = 1'b1;
        state_d       = S_VSCALE;
      end
      S_VSCALE: begin
        cmd_o.set_s_vol = 1'b1;
        state_d         = S_DISPATCH;
      end
      S_DISPATCH: begin
        priority if (status_i.rates_eq) state_d = S_PASS;
        else if (status_i.first) state_d = S_BMUL;
        else state_d = S_MARK;
      end
      S_PASS: begin
        cmd_o.emit = 1'b1;
        state_d    = S_FINISH;
      end
      S_BMUL: begin
        cmd_o.blk_mul = 1'b1;
        state_d       = S_CSTART;
      end
      S_CSTART: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_COUNT;
        state_d         = S_CWAIT;
      end
      S_CWAIT: begin
        cmd_o.div_sel = DIV_COUNT;
        if (status_i.div_done) begin
          cmd_o.set_count = 1'b1;
          state_d         = S_CHECK;
        end
      end
      S_CHECK: state_d = status_i.step_needed ? S_SSTART : S_MARK;
      S_SSTART: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = DIV_STEP;
        state_d         = S_SWAIT;
      end
      S_SWAIT: if (status_i.div_done) begin
        cmd_o.set_step = 1'b1;
        state_d        = S_MARK;
      end
      S_MARK: begin
        cmd_o.mark_before = 1'b1;
        state_d = (status_i.first && status_i.flat) ? S_FLAT : S_ILOOP;
      end
      S_FLAT: begin
        if (status_i.fill) begin
          cmd_o.emit  = 1'b1;
          cmd_o.count = 1'b1;
        end else state_d = S_ILOOP;
      end
      S_ILOOP: begin
        priority if (status_i.interp) begin
          cmd_o.int_mul = 1'b1;
          state_d       = S_IEMIT;
        end else if (status_i.last) state_d = S_FILL;
        else state_d = S_FINISH;
      end
      S_IEMIT: begin
        cmd_o.emit     = 1'b1;
        cmd_o.count    = 1'b1;
        cmd_o.emit_sel = EMIT_INTERP;
        state_d        = S_ILOOP;
      end
      S_FILL: begin
        if (status_i.fill) begin
          cmd_o.emit  = 1'b1;
          cmd_o.count = 1'b1;
        end else state_d = S_FINISH;
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = status_i.kept_zero ? S_IDLE : S_READ;
      end
      S_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = S_SHOW;
      end
      S_SHOW: if (out_ready_i) begin
        cmd_o.rd_next = 1'b1;
        state_d       = status_i.rd_last ? S_IDLE : S_READ;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= S_IDLE;
    else state_q <= state_d;
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = state_q == S_SHOW;

  a_show_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !status_i.kept_zero) else $error("result shown from empty buffer");
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o)) else $error("input taken while draining");
  a_finish_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.finish |=> !cmd_o.finish) else $error("frame closed twice");

endmodule

@@ tb/sv/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Drives audio frames and APB register writes into the linear resampler and
// checks every result against a cycle-free prediction of the converter.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class resample_scoreboard;
  typedef struct packed {
    logic signed [15:0] smp;
    logic               lor;
    logic               eob;
    logic               ovf;
  } res_t;

  res_t pending[$];
  int   errors;

  // prediction state
  logic [17:0] src_rate, out_rate;
  logic [6:0]  vol;
  logic [17:0] rem;
  logic [11:0] fidx;
  logic [15:0] prev;
  logic [15:0] bcount, emitted;
  logic [43:0] pos, step;
  res_t        run[$];
  int          total;

  function new();
    src_rate = 18'd48000; out_rate = 18'd48000; vol = 7'd100;
    rem = '0; fidx = '0; prev = '0; bcount = '0; emitted = '0; pos = '0; step = '0;
    errors = 0;
  endfunction

  function void write_reg(int idx, logic [31:0] v);
    if (idx == 0) src_rate = v[17:0];
    else if (idx == 1) out_rate = v[17:0];
    else vol = v[6:0];
  endfunction

  function automatic int clip16(longint v);
    if (v < -32768) return -32768;
    if (v > 32767) return 32767;
    return int'(v);
  endfunction

  function void push(int v);
    res_t r;
    r.smp = v[15:0]; r.lor = 0; r.eob = 0; r.ovf = 0;
    if (run.size() < 64) run.push_back(r);
    total++;
  endfunction

  function void note_frame(logic md, logic signed [15:0] a, logic signed [15:0] b,
                           logic [12:0] bf);
    int          frames, s, mixed, prior, k, lo, n;
    bit          last, eob;
    longint      scaled, cnt, p, q;
    logic [31:0] div;
    logic [15:0] frac;
    frames = bf;
    if (frames == 0) frames = 1;
    if (frames > 4096) frames = 4096;
    k = fidx;
    last = (k + 1 >= frames);
    if (md) begin
      mixed = (int'(a) + int'(b)) / 2;
      s = clip16((longint'(mixed) * int'(vol)) / 100);
    end else begin
      s = a;
    end
    run.delete();
    total = 0;
    eob = 0;
    if (src_rate == out_rate) begin
      push(s);
      eob = last;
    end else begin
      if (k == 0) begin
        div = (src_rate == 0) ? 1 : src_rate;
        scaled = longint'(frames) * out_rate + rem;
        cnt = scaled / div;
        rem = 18'(scaled % div);
        bcount = (cnt > 65535) ? 16'hffff : cnt[15:0];
        emitted = 0; pos = 0; step = 0;
        if (bcount >= 2 && frames >= 2)
          step = 44'((longint'(frames - 1) << 32) / (bcount - 1));
      end
      prior = emitted;
      if (k == 0 && (bcount == 1 || frames == 1))
        while (emitted < bcount) begin push(s); emitted++; end
      while (emitted < bcount && (pos >> 32) < k) begin
        frac = pos[31:16];
        p = (longint'(s) - longint'($signed(prev))) * frac;
        if (p >= 0) q = p >>> 16;
        else q = -(((-p) + 65535) >>> 16);
        push(clip16(longint'($signed(prev)) + q));
        emitted++;
        pos = pos + step;
      end
      if (last)
        while (emitted < bcount) begin push(s); emitted++; end
      eob = (prior < bcount && emitted == bcount);
    end
    prev = s[15:0];
    fidx = last ? 12'd0 : 12'(k + 1);
    n = run.size();
    for (int j = 0; j < n; j++) begin
      if (total > n) run[j].ovf = 1;
      if (j == n - 1) begin run[j].lor = 1; run[j].eob = eob; end
      pending.push_back(run[j]);
    end
  endfunction

  function void check(res_t got);
    res_t exp_r;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result %h", $time, got);
      errors++;
      return;
    end
    exp_r = pending.pop_front();
    if (got !== exp_r) begin
      $display("%0t: mismatch expected smp=%0d lor=%b eob=%b ovf=%b actual smp=%0d lor=%b eob=%b ovf=%b",
               $time, exp_r.smp, exp_r.lor, exp_r.eob, exp_r.ovf,
               got.smp, got.lor, got.eob, got.ovf);
      errors++;
    end
  endfunction
endclass

module tb_top;
  import alr_pkg::*;

  logic clk_i, rst_ni;
  logic psel, penable, pwrite;
  logic [APB_AW-1:0] paddr;
  logic [APB_DW-1:0] pwdata, prdata;
  logic pready;

  alr_in_if  frm_if();
  alr_out_if res_if();

  audio_block_linear_resampler_top dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .in_i(frm_if.sink), .out_o(res_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  resample_scoreboard sb = new();
  int  send_idle_pct, recv_idle_pct;
  bit  hold_recv;
  int  quiet_cycles;

  initial begin
    clk_i = 0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    frm_if.valid = 0; frm_if.mode = 0; frm_if.sample_a = '0; frm_if.sample_b = '0;
    frm_if.block_frames = 13'd1;
    res_if.ready = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
    send_idle_pct = 0; recv_idle_pct = 0; hold_recv = 0;
  end

  // receiver
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (res_if.valid && res_if.ready)
        sb.check({res_if.out_sample, res_if.last_of_run, res_if.end_of_block,
                  res_if.overflow});
      res_if.ready <= !hold_recv && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // watchdog
  always @(posedge clk_i) begin
    if (!rst_ni || (frm_if.valid && frm_if.ready) || (res_if.valid && res_if.ready))
      quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > 1000000) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [31:0] v);
    @(posedge clk_i);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= APB_AW'(idx) << 2; pwdata <= v;
    @(posedge clk_i);
    penable <= 1;
    @(posedge clk_i);
    psel <= 0; penable <= 0; pwrite <= 0;
    sb.write_reg(idx, v);
  endtask

  // the block is busy after an accept, so the spacing before the next frame
  // costs nothing and keeps the valid drop and raise apart
  task automatic send_frame(logic md, logic signed [15:0] a, logic signed [15:0] b,
                            logic [12:0] bf);
    @(posedge clk_i);
    while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    frm_if.valid <= 1; frm_if.mode <= md; frm_if.sample_a <= a;
    frm_if.sample_b <= b; frm_if.block_frames <= bf;
    @(posedge clk_i);
    while (!frm_if.ready) @(posedge clk_i);
    sb.note_frame(md, a, b, bf);
    frm_if.valid <= 0;
  endtask

  task automatic drain();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (300) @(posedge clk_i);
  endtask

  // well-formed block of random frames, short sizes mostly
  task automatic send_block(int bf);
    for (int i = 0; i < bf; i++)
      send_frame($urandom_range(1), 16'($urandom), 16'($urandom), 13'(bf));
  endtask

  task automatic set_rates(logic [31:0] s, logic [31:0] o, logic [31:0] v);
    drain();
    reg_write(REG_SRC_RATE, s);
    reg_write(REG_OUTPUT_RATE, o);
    reg_write(REG_VOLUME, v);
  endtask

  initial begin
    int bf, sel;
    rst_ni = 0;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: pass-through extremes, stereo saturation
    send_frame(0, 16'sh7fff, 0, 13'd1);
    send_frame(0, -16'sd32768, 0, 13'd0);
    send_frame(1, 16'sh7fff, 16'sh7fff, 13'd8191);
    send_frame(1, -16'sd32768, -16'sd32767, 13'd4096);
    set_rates(32'd0, 32'd0, 32'd127);
    send_frame(1, 16'sh7fff, 16'sh7fff, 13'd1);
    send_frame(1, -16'sd32768, -16'sd32768, 13'd1);
    set_rates(32'd3, 32'd4, 32'd0);
    send_frame(1, 16'sd1000, 16'sd3, 13'd3);
    send_frame(0, -16'sd32768, 0, 13'd3);
    send_frame(0, 16'sh7fff, 0, 13'd3);
    set_rates(32'd0, 32'd2, 32'd50);          // zero source rate
    send_frame(0, 16'sd5, 0, 13'd1);          // flat block
    send_frame(0, 16'sd7, 0, 13'd40);         // block of 80 outputs starts
    send_frame(0, -16'sd7, 0, 13'd2);         // length shrinks, results cut at 64
    set_rates(32'd192000, 32'd1, 32'd100);    // empty block of two frames
    send_frame(0, 16'sd9, 0, 13'd2);
    send_frame(0, 16'sd9, 0, 13'd2);
    set_rates(32'd1, 32'd192000, 32'd100);    // huge count saturates
    send_frame(0, 16'sd1, 0, 13'd1);
    set_rates(32'd48000, 32'd44100, 32'd100);
    send_block(5);

    // random phases
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 37 : (ph == 1) ? 83 : 0;
      recv_idle_pct = (ph == 0) ? 83 : (ph == 1) ? 37 : 0;
      for (int r = 0; r < 4; r++) begin
        sel = $urandom_range(3);
        case (sel)
          0: set_rates(32'd48000, 32'd48000, $urandom_range(100));
          1: set_rates($urandom_range(192000, 1), $urandom_range(192000, 1),
                       $urandom_range(127));
          2: set_rates(32'd44100 + $urandom_range(200), 32'd48000, $urandom_range(100));
          default: set_rates(32'd8000 + $urandom_range(99), 32'd16000 + $urandom_range(99),
                             $urandom_range(100));
        endcase
        if (ph == 2 && r == 0) fork
          begin hold_recv = 1; repeat (400) @(posedge clk_i); hold_recv = 0; end
        join_none
        for (int n = 0; n < 25; ) begin
          bf = ($urandom_range(9) == 0) ? $urandom_range(40, 1) : $urandom_range(6, 1);
          if ($urandom_range(9) == 0) begin
            send_frame($urandom_range(1), 16'($urandom), 16'($urandom), 13'($urandom));
            n++;
          end else begin
            send_block(bf);
            n += bf;
          end
        end
      end
    end

    drain();
    if (sb.errors == 0) $display("== PASS ==");
    else $display("== FAIL ==");
    $finish;
  end
endmodule
